FILE: hw/rtl/gde_pkg.sv
// Shared types, codes and calendar helper functions of the Gregorian date engine.
package gde_pkg;

  localparam logic [11:0] YearMin = 12'd1400;
  localparam logic [11:0] YearMax = 12'd2400;
  localparam logic [8:0]  Cycle400Last = 9'd399;
  localparam int unsigned EntryWidth = 20;

  typedef enum logic [2:0] {
    MODE_WEEKDAY,
    MODE_SHIFT,
    MODE_NEXT_WD,
    MODE_NEXT_WE,
    MODE_ADD_HOL,
    MODE_COUNT,
    MODE_COMPARE,
    MODE_UNUSED
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_INVALID,
    ST_FULL,
    ST_RANGE
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD400,
    S_CHECK,
    S_MOD100,
    S_MOD7,
    S_DISPATCH,
    S_WALK,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_COUNT,
    S_DONE
  } state_e;

  typedef struct packed {
    mode_e       mode;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [15:0] offset;
    logic [4:0]  other_day;
    logic [3:0]  other_month;
    logic [11:0] other_year;
  } request_t;

  typedef struct packed {
    status_e     status;
    logic        precedes;
    logic [4:0]  days_off;
    logic [2:0]  weekday;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } result_t;

  // leap year from the year modulo 400
  function automatic logic is_leap(logic [8:0] r400);
    logic div100;
    div100 = (r400 == 9'd0) || (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
    return (r400 == 9'd0) || ((r400[1:0] == 2'b00) && !div100);
  endfunction

  function automatic logic [4:0] days_in(logic [3:0] m, logic leap);
    logic [4:0] n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // (13 * (m + 1)) / 5 for the shifted month 3..14
  function automatic logic [5:0] zeller_month(logic [3:0] m);
    logic [5:0] t;
    unique case (m)
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      4'd13:   t = 6'd36;
      4'd14:   t = 6'd39;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

endpackage

FILE: hw/rtl/gde_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gde_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/gde_alu.sv
// Shared subtract-and-compare unit used for all modulo reductions.
module gde_alu (
  input  logic [11:0] a_i,
  input  logic [11:0] b_i,
  output logic [11:0] diff_o,
  output logic        ge_o
);

  logic [12:0] sub;

  assign sub    = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = sub[11:0];
  assign ge_o   = !sub[12];

endmodule

FILE: hw/rtl/gde_core.sv
// Sequencer of the date engine: validation, Zeller weekday, day walk, holiday add, month count and date compare.
module gde_core #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  gde_pkg::request_t     req_i,
  output logic                  req_ready_o,
  output logic                  res_valid_o,
  output gde_pkg::result_t      res_o,
  input  logic                  res_ready_i,
  output logic                  ram_we_o,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] ram_waddr_o,
  output logic [gde_pkg::EntryWidth-1:0]              ram_wdata_o,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] ram_raddr_o,
  input  logic [gde_pkg::EntryWidth-1:0]              ram_rdata_i
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  gde_pkg::state_e  state_q, state_d;
  gde_pkg::mode_e   mode_q, mode_d;
  gde_pkg::status_e st_q, st_d;
  logic [4:0]  d_q, d_d;
  logic [3:0]  m_q, m_d;
  logic [11:0] y_q, y_d;
  logic [8:0]  r400_q, r400_d;
  logic [2:0]  wd_q, wd_d;
  logic [15:0] n_q, n_d;
  logic        back_q, back_d;
  logic [11:0] acc_q, acc_d;
  logic [5:0]  j_q, j_d;
  logic [3:0]  zm_q, zm_d;
  logic [31:0] mask_q, mask_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] count_q, count_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        prec_q, prec_d;

  logic [11:0] alu_b, alu_diff;
  logic        alu_ge;

  gde_alu u_alu (
    .a_i   (acc_q),
    .b_i   (alu_b),
    .diff_o(alu_diff),
    .ge_o  (alu_ge)
  );

  logic        leap_cur;
  logic [4:0]  dim_cur;
  logic [4:0]  fd, bd;
  logic [3:0]  fm, bm;
  logic [11:0] fy, by;
  logic [8:0]  fr, br;
  logic [2:0]  wd_fwd, wd_back;
  logic [11:0] yoff;
  logic [14:0] key;
  logic [11:0] zsum;
  logic [2:0]  h;

  always_comb begin
    leap_cur = gde_pkg::is_leap(r400_q);
    dim_cur  = gde_pkg::days_in(m_q, leap_cur);
    wd_fwd   = (wd_q == 3'd6) ? 3'd0 : wd_q + 3'd1;
    wd_back  = (wd_q == 3'd0) ? 3'd6 : wd_q - 3'd1;
    // next day
    fd = d_q + 5'd1;
    fm = m_q;
    fy = y_q;
    fr = r400_q;
    if (d_q >= dim_cur) begin
      fd = 5'd1;
      if (m_q >= 4'd12) begin
        fm = 4'd1;
        fy = y_q + 12'd1;
        fr = (r400_q == gde_pkg::Cycle400Last) ? 9'd0 : r400_q + 9'd1;
      end else begin
        fm = m_q + 4'd1;
      end
    end
    // previous day
    bd = d_q - 5'd1;
    bm = m_q;
    by = y_q;
    br = r400_q;
    if (d_q <= 5'd1) begin
      if (m_q > 4'd1) begin
        bm = m_q - 4'd1;
      end else begin
        bm = 4'd12;
        by = y_q - 12'd1;
        br = (r400_q == 9'd0) ? gde_pkg::Cycle400Last : r400_q - 9'd1;
      end
      bd = gde_pkg::days_in(bm, gde_pkg::is_leap(br));
    end
    yoff = y_q - gde_pkg::YearMin;
    key  = {1'b0, yoff[9:0], m_q};
    zsum = {7'b0, d_q} + {6'b0, gde_pkg::zeller_month(zm_q)} + {5'b0, acc_q[6:0]}
         + {7'b0, acc_q[6:2]} + {8'b0, j_q[5:2]} + {4'b0, j_q, 2'b0} + {6'b0, j_q};
    h = acc_q[2:0];
  end

  assign ram_waddr_o = count_q[AW-1:0];
  assign ram_wdata_o = {1'b0, yoff[9:0], m_q, d_q};
  assign ram_raddr_o = idx_q[AW-1:0];

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    st_d    = st_q;
    d_d     = d_q;
    m_d     = m_q;
    y_d     = y_q;
    r400_d  = r400_q;
    wd_d    = wd_q;
    n_d     = n_q;
    back_d  = back_q;
    acc_d   = acc_q;
    j_d     = j_q;
    zm_d    = zm_q;
    mask_d  = mask_q;
    idx_d   = idx_q;
    count_d = count_q;
    cnt_d   = cnt_q;
    prec_d  = prec_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    unique case (state_q)
      gde_pkg::S_MOD400: alu_b = 12'd400;
      gde_pkg::S_MOD100: alu_b = 12'd100;
      default:           alu_b = 12'd7;
    endcase

    unique case (state_q)
      gde_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          mode_d = req_i.mode;
          d_d    = (req_i.mode == gde_pkg::MODE_COUNT) ? 5'd1 : req_i.day;
          m_d    = req_i.month;
          y_d    = req_i.year;
          n_d    = req_i.offset[15] ? (~req_i.offset + 16'd1) : req_i.offset;
          back_d = req_i.offset[15];
          acc_d  = req_i.year;
          st_d   = gde_pkg::ST_OK;
          wd_d   = 3'd0;
          cnt_d  = 5'd0;
          if (req_i.year != req_i.other_year) begin
            prec_d = req_i.year < req_i.other_year;
          end else if (req_i.month != req_i.other_month) begin
            prec_d = req_i.month < req_i.other_month;
          end else begin
            prec_d = req_i.day < req_i.other_day;
          end
          if (req_i.mode == gde_pkg::MODE_COMPARE) begin
            state_d = gde_pkg::S_DONE;
          end else if (req_i.mode == gde_pkg::MODE_UNUSED) begin
            st_d    = gde_pkg::ST_INVALID;
            state_d = gde_pkg::S_DONE;
          end else begin
            state_d = gde_pkg::S_MOD400;
          end
        end
      end
      gde_pkg::S_MOD400: begin
        if (alu_ge) begin
          acc_d = alu_diff;
        end else begin
          r400_d  = acc_q[8:0];
          state_d = gde_pkg::S_CHECK;
        end
      end
      gde_pkg::S_CHECK: begin
        if (m_q == 4'd0 || m_q > 4'd12 || (mode_q != gde_pkg::MODE_COUNT &&
            (d_q == 5'd0 || d_q > dim_cur))) begin
          st_d    = gde_pkg::ST_INVALID;
          state_d = gde_pkg::S_DONE;
        end else if (y_q < gde_pkg::YearMin || y_q > gde_pkg::YearMax) begin
          st_d    = gde_pkg::ST_RANGE;
          state_d = gde_pkg::S_DONE;
        end else begin
          j_d = 6'd0;
          if (m_q < 4'd3) begin
            acc_d = y_q - 12'd1;
            zm_d  = m_q + 4'd12;
          end else begin
            acc_d = y_q;
            zm_d  = m_q;
          end
          state_d = gde_pkg::S_MOD100;
        end
      end
      gde_pkg::S_MOD100: begin
        if (alu_ge) begin
          acc_d = alu_diff;
          j_d   = j_q + 6'd1;
        end else begin
          acc_d   = zsum;
          state_d = gde_pkg::S_MOD7;
        end
      end
      gde_pkg::S_MOD7: begin
        if (alu_ge) begin
          acc_d = alu_diff;
        end else begin
          wd_d    = (h == 3'd0) ? 3'd6 : h - 3'd1;
          state_d = gde_pkg::S_DISPATCH;
        end
      end
      gde_pkg::S_DISPATCH: begin
        priority case (mode_q)
          gde_pkg::MODE_SHIFT: begin
            state_d = (n_q == 16'd0) ? gde_pkg::S_DONE : gde_pkg::S_WALK;
          end
          gde_pkg::MODE_NEXT_WD, gde_pkg::MODE_NEXT_WE: begin
            state_d = gde_pkg::S_WALK;
          end
          gde_pkg::MODE_ADD_HOL: begin
            if (count_q >= CW'(SLOTS)) begin
              st_d = gde_pkg::ST_FULL;
            end else begin
              ram_we_o = 1'b1;
              count_d  = count_q + CW'(1);
            end
            state_d = gde_pkg::S_DONE;
          end
          gde_pkg::MODE_COUNT: begin
            mask_d  = 32'd0;
            idx_d   = '0;
            state_d = (count_q == '0) ? gde_pkg::S_COUNT : gde_pkg::S_SCAN_RD;
          end
          default: state_d = gde_pkg::S_DONE;
        endcase
      end
      gde_pkg::S_WALK: begin
        if (mode_q == gde_pkg::MODE_SHIFT && back_q) begin
          d_d = bd; m_d = bm; y_d = by; r400_d = br; wd_d = wd_back;
        end else begin
          d_d = fd; m_d = fm; y_d = fy; r400_d = fr; wd_d = wd_fwd;
        end
        if (mode_q == gde_pkg::MODE_SHIFT) begin
          n_d = n_q - 16'd1;
          if (n_q == 16'd1) state_d = gde_pkg::S_DONE;
        end else if (mode_q == gde_pkg::MODE_NEXT_WD) begin
          if (wd_fwd != 3'd0 && wd_fwd != 3'd6) state_d = gde_pkg::S_DONE;
        end else begin
          if (wd_fwd == 3'd0 || wd_fwd == 3'd6) state_d = gde_pkg::S_DONE;
        end
      end
      gde_pkg::S_SCAN_RD: begin
        state_d = gde_pkg::S_SCAN_CMP;
      end
      gde_pkg::S_SCAN_CMP: begin
        if (ram_rdata_i[19:5] == key) mask_d[ram_rdata_i[4:0]] = 1'b1;
        idx_d   = idx_q + CW'(1);
        state_d = (idx_q + CW'(1) == count_q) ? gde_pkg::S_COUNT : gde_pkg::S_SCAN_RD;
      end
      gde_pkg::S_COUNT: begin
        if (wd_q == 3'd0 || wd_q == 3'd6 || mask_q[d_q]) cnt_d = cnt_q + 5'd1;
        if (d_q >= dim_cur) begin
          state_d = gde_pkg::S_DONE;
        end else begin
          d_d  = d_q + 5'd1;
          wd_d = wd_fwd;
        end
      end
      gde_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = gde_pkg::S_IDLE;
      end
      default: state_d = gde_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    res_o        = '0;
    res_o.status = st_q;
    if (st_q == gde_pkg::ST_OK) begin
      unique case (mode_q)
        gde_pkg::MODE_WEEKDAY, gde_pkg::MODE_SHIFT, gde_pkg::MODE_NEXT_WD,
        gde_pkg::MODE_NEXT_WE, gde_pkg::MODE_ADD_HOL: begin
          res_o.day     = d_q;
          res_o.month   = m_q;
          res_o.year    = y_q;
          res_o.weekday = wd_q;
          if (y_q < gde_pkg::YearMin || y_q > gde_pkg::YearMax) begin
            res_o.status = gde_pkg::ST_RANGE;
          end
        end
        gde_pkg::MODE_COUNT: begin
          res_o.month    = m_q;
          res_o.year     = y_q;
          res_o.days_off = cnt_q;
        end
        gde_pkg::MODE_COMPARE: res_o.precedes = prec_q;
        default: res_o.status = gde_pkg::ST_INVALID;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gde_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    st_q   <= st_d;
    d_q    <= d_d;
    m_q    <= m_d;
    y_q    <= y_d;
    r400_q <= r400_d;
    wd_q   <= wd_d;
    n_q    <= n_d;
    back_q <= back_d;
    acc_q  <= acc_d;
    j_q    <= j_d;
    zm_q   <= zm_d;
    mask_q <= mask_d;
    idx_q  <= idx_d;
    cnt_q  <= cnt_d;
    prec_q <= prec_d;
  end

endmodule

FILE: hw/rtl/gregorian_date_engine_top.sv
// Top level of the Gregorian date engine: stream ports, holiday table and result register.
// One request is worked at a time; s_axis_tready is high only while the sequencer is idle,
// and a finished result waits in the output register without blocking the next request.
// Work runs on the shared subtract unit and the one-day-per-cycle walk: validation
// and the Zeller weekday (year mod 400, mod 100 and mod 7 by repeated subtraction)
// come first, then a walk of |offset| days for a shift or to the next weekday or
// weekend day for a search, a table write for a holiday add, and a read and compare
// of each stored holiday plus one step per day of the month for a month count.
module gregorian_date_engine_top #(
  parameter int unsigned HOLIDAY_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // in_day, in_month, in_year, offset, other_day, other_month, other_year
  input  logic [63:0] s_axis_tdata,
  // mode
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_day, out_month, out_year, weekday, days_off, precedes, status
  output logic [31:0] m_axis_tdata
);

  localparam int unsigned AW = (HOLIDAY_SLOTS > 1) ? $clog2(HOLIDAY_SLOTS) : 1;

  gde_pkg::request_t req;
  gde_pkg::result_t  res, out_q;
  logic              res_valid, res_ready, out_valid_q;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [gde_pkg::EntryWidth-1:0] ram_wdata, ram_rdata;

  always_comb begin
    req.mode        = gde_pkg::mode_e'(s_axis_tuser);
    req.day         = s_axis_tdata[4:0];
    req.month       = s_axis_tdata[8:5];
    req.year        = s_axis_tdata[20:9];
    req.offset      = s_axis_tdata[36:21];
    req.other_day   = s_axis_tdata[41:37];
    req.other_month = s_axis_tdata[45:42];
    req.other_year  = s_axis_tdata[57:46];
  end

  gde_core #(
    .SLOTS(HOLIDAY_SLOTS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid),
    .req_i      (req),
    .req_ready_o(s_axis_tready),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_ready_i(res_ready),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata)
  );

  gde_ram #(
    .WIDTH(gde_pkg::EntryWidth),
    .DEPTH(HOLIDAY_SLOTS)
  ) u_holidays (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule
